// ----- sv/ptl_pkg.sv -----
package ptl_pkg;

    // Configuration port geometry
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 8;

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PHASE_TICKS  = 1'b0,
        CFG_BLINK_CYCLES = 1'b1
    } t_cfg_idx;

    // Register reset values
    localparam logic [7:0] PHASE_TICKS_RST  = 8'd10;
    localparam logic [4:0] BLINK_CYCLES_RST = 5'd5;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [4:0] blink_cycles;
    } t_cfg;

    // One result word: the six lamps
    typedef struct packed {
        logic car_green;
        logic car_yellow;
        logic car_red;
        logic walk_green;
        logic walk_yellow;
        logic walk_red;
    } t_lamps;

endpackage

// ----- sv/ptl_if.sv -----
// Event channel: one word per timer tick or button press edge
interface ptl_in_if;
    logic valid;
    logic ready;
    logic op;
    logic button_level;
    modport source (output valid, op, button_level, input ready);
    modport sink   (input valid, op, button_level, output ready);
endinterface

// Lamp channel: one word per event
interface ptl_out_if;
    logic valid;
    logic ready;
    logic car_green;
    logic car_yellow;
    logic car_red;
    logic walk_green;
    logic walk_yellow;
    logic walk_red;
    modport source (output valid, car_green, car_yellow, car_red,
                    walk_green, walk_yellow, walk_red, input ready);
    modport sink   (input valid, car_green, car_yellow, car_red,
                    walk_green, walk_yellow, walk_red, output ready);
endinterface

// Register write channel
interface ptl_cfg_if import ptl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ptl_cfg_regs.sv -----
module ptl_cfg_regs import ptl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptl_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    logic [7:0] r_phase_ticks;
    logic [4:0] r_blink_cycles;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks  <= PHASE_TICKS_RST;
            r_blink_cycles <= BLINK_CYCLES_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PHASE_TICKS:  r_phase_ticks  <= i_cfg.data[7:0];
                CFG_BLINK_CYCLES: r_blink_cycles <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.phase_ticks  = r_phase_ticks;
    assign o_cfg.blink_cycles = r_blink_cycles;

endmodule

// ----- sv/ptl_core.sv -----
module ptl_core import ptl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_fire,
    input  logic   i_op,
    input  logic   i_button_level,
    input  t_cfg   i_cfg,
    output t_lamps o_lamps
);

    typedef enum logic [3:0] {
        PH_GREEN     = 4'd0,
        PH_BLINK1    = 4'd1,
        PH_RED       = 4'd2,
        PH_BLINK2    = 4'd3,
        PH_PA_GREEN  = 4'd4,
        PH_PA_BLINK1 = 4'd5,
        PH_PA_BLINK2 = 4'd6,
        PH_PRED_GEN  = 4'd7,
        PH_PRED_EXT  = 4'd8,
        PH_PB_KEEP   = 4'd9,
        PH_PB_BARE   = 4'd10
    } t_phase;

    localparam t_phase PH_LAST = PH_PB_BARE;

    function automatic logic is_normal(t_phase p);
        return p <= PH_BLINK2;
    endfunction

    function automatic logic is_blink(t_phase p);
        return p == PH_BLINK1 || p == PH_BLINK2 || p == PH_PA_GREEN ||
               p == PH_PA_BLINK1 || p == PH_PA_BLINK2 || p == PH_PB_KEEP ||
               p == PH_PB_BARE;
    endfunction

    function automatic t_phase next_phase(t_phase p);
        t_phase q;
        case (p)
            PH_GREEN:     q = PH_BLINK1;
            PH_BLINK1:    q = PH_RED;
            PH_RED:       q = PH_BLINK2;
            PH_PA_GREEN,
            PH_PA_BLINK1,
            PH_PA_BLINK2: q = PH_PRED_GEN;
            PH_PRED_GEN:  q = PH_PB_KEEP;
            PH_PRED_EXT:  q = PH_PB_BARE;
            default:      q = PH_GREEN;
        endcase
        return q;
    endfunction

    t_phase     r_phase,       n_phase;
    logic [7:0] r_tick_count,  n_tick_count;
    logic [4:0] r_blink_count, n_blink_count;
    logic       r_blink_on,    n_blink_on;
    logic       r_pending,     n_pending;
    logic       r_checking,    n_checking;

    // Next state for one event
    always_comb begin
        logic       go;
        t_phase     target;
        logic [7:0] tick_lim;
        logic [4:0] blink_lim;
        logic [7:0] tick_inc;
        logic [4:0] blink_inc;

        go        = 1'b0;
        target    = PH_GREEN;
        tick_lim  = (i_cfg.phase_ticks == 8'd0) ? 8'd1 : i_cfg.phase_ticks;
        blink_lim = (i_cfg.blink_cycles == 5'd0) ? 5'd1 : i_cfg.blink_cycles;

        // An unknown phase code falls back to car green, all cleared
        if (r_phase > PH_LAST) begin
            n_phase       = PH_GREEN;
            n_tick_count  = 8'd0;
            n_blink_count = 5'd0;
            n_blink_on    = 1'b0;
            n_pending     = 1'b0;
            n_checking    = 1'b0;
        end else begin
            n_phase       = r_phase;
            n_tick_count  = r_tick_count;
            n_blink_count = r_blink_count;
            n_blink_on    = r_blink_on;
            n_pending     = r_pending;
            n_checking    = r_checking;
        end
        tick_inc  = n_tick_count + 8'd1;
        blink_inc = n_blink_count + 5'd1;

        if (i_op) begin
            // Press edge: latch a request in the normal cycle only
            if (is_normal(n_phase) && !n_checking && !n_pending) begin
                n_pending = 1'b1;
                if (n_phase == PH_GREEN || n_phase == PH_RED)
                    n_checking = 1'b1;
            end
        end else if (n_checking) begin
            // Check tick: long press drops the request, short one starts the walk
            n_checking = 1'b0;
            n_pending  = 1'b0;
            if (i_button_level) begin
                if (is_blink(n_phase))
                    n_blink_on = 1'b1;
            end else begin
                go = 1'b1;
                case (n_phase)
                    PH_GREEN:  target = PH_PA_GREEN;
                    PH_BLINK1: target = PH_PA_BLINK1;
                    PH_RED:    target = PH_PRED_EXT;
                    default:   target = PH_PA_BLINK2;
                endcase
            end
        end else if (is_blink(n_phase)) begin
            // Blink: on half then off half; count at the start of each cycle
            if (n_blink_on) begin
                n_blink_on = 1'b0;
            end else begin
                n_blink_count = blink_inc;
                if (blink_inc >= blink_lim) begin
                    go     = 1'b1;
                    target = next_phase(n_phase);
                end else if (is_normal(n_phase) && n_pending) begin
                    n_checking = 1'b1;
                end else begin
                    n_blink_on = 1'b1;
                end
            end
        end else begin
            // Steady phase timer
            n_tick_count = tick_inc;
            if (tick_inc >= tick_lim) begin
                go     = 1'b1;
                target = next_phase(n_phase);
            end
        end

        // Phase entry
        if (go) begin
            n_phase       = target;
            n_tick_count  = 8'd0;
            n_blink_count = 5'd0;
            n_blink_on    = is_blink(target);
            if (is_normal(target) && n_pending) begin
                n_checking = 1'b1;
                n_blink_on = 1'b0;
            end
        end
    end

    // Lamps after the event
    always_comb begin
        o_lamps = '0;
        unique case (n_phase)
            PH_GREEN: begin
                o_lamps.car_green = 1'b1;
                o_lamps.walk_red  = 1'b1;
            end
            PH_BLINK1: begin
                o_lamps.car_yellow = n_blink_on;
                o_lamps.walk_red   = 1'b1;
            end
            PH_RED: begin
                o_lamps.car_red    = 1'b1;
                o_lamps.walk_green = 1'b1;
            end
            PH_BLINK2: begin
                o_lamps.car_yellow = n_blink_on;
            end
            PH_PA_GREEN: begin
                o_lamps.car_green   = 1'b1;
                o_lamps.walk_red    = 1'b1;
                o_lamps.car_yellow  = n_blink_on;
                o_lamps.walk_yellow = n_blink_on;
            end
            PH_PA_BLINK1: begin
                o_lamps.walk_red    = 1'b1;
                o_lamps.car_yellow  = n_blink_on;
                o_lamps.walk_yellow = n_blink_on;
            end
            PH_PRED_GEN, PH_PRED_EXT: begin
                o_lamps.car_red    = 1'b1;
                o_lamps.walk_green = 1'b1;
            end
            PH_PB_KEEP: begin
                o_lamps.car_red     = 1'b1;
                o_lamps.walk_green  = 1'b1;
                o_lamps.car_yellow  = n_blink_on;
                o_lamps.walk_yellow = n_blink_on;
            end
            default: begin
                o_lamps.car_yellow  = n_blink_on;
                o_lamps.walk_yellow = n_blink_on;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_GREEN;
            r_tick_count  <= 8'd0;
            r_blink_count <= 5'd0;
            r_blink_on    <= 1'b0;
            r_pending     <= 1'b0;
            r_checking    <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_tick_count  <= n_tick_count;
            r_blink_count <= n_blink_count;
            r_blink_on    <= n_blink_on;
            r_pending     <= n_pending;
            r_checking    <= n_checking;
        end
    end

    // A running check always belongs to a pending request
    a_check_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_checking |-> r_pending)
        else $error("check running without a pending request");

    // Checks happen only in the normal cycle, with the yellow lamp off
    a_check_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_checking |-> (is_normal(r_phase) && !r_blink_on))
        else $error("check outside the normal cycle or with yellow on");

    // A short press on the check tick leaves the normal cycle
    a_short_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_op && r_checking && !i_button_level) |=>
            (!is_normal(r_phase) && !r_pending))
        else $error("short press did not start pedestrian mode");

    // Phase code stays in range
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_LAST)
        else $error("phase code out of range");

endmodule

// ----- sv/ptl_out_reg.sv -----
module ptl_out_reg import ptl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_lamps    i_lamps,
    output logic      o_space,
    ptl_out_if.source o_out
);

    logic   r_valid;
    t_lamps r_lamps;

    // Room for a new word when empty or when the held word leaves now
    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lamps <= i_lamps;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.car_green   = r_lamps.car_green;
    assign o_out.car_yellow  = r_lamps.car_yellow;
    assign o_out.car_red     = r_lamps.car_red;
    assign o_out.walk_green  = r_lamps.walk_green;
    assign o_out.walk_yellow = r_lamps.walk_yellow;
    assign o_out.walk_red    = r_lamps.walk_red;

endmodule

// ----- sv/pedestrian_traffic_light_fsm_unit.sv -----
// Pedestrian crossing light controller. Each word on i_in is one event, a
// half-second timer tick (op 0, with the button level sampled at that tick)
// or a button press edge (op 1), and yields exactly one word on o_out with
// the six lamps as they stand after the event. Each event
// is applied to the sequencer state and the lamps land in the output
// register at the same edge, so a new event is taken every cycle while the
// output register is empty or being drained. Registers phase_ticks (index
// 0) and blink_cycles (index 1) set the steady phase length in ticks and
// the number of yellow on-off cycles; a value of zero acts as one. Write
// them only while no events are in flight.
module pedestrian_traffic_light_fsm_unit import ptl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptl_in_if.sink    i_in,
    ptl_cfg_if.sink   i_cfg,
    ptl_out_if.source o_out
);

    t_cfg   cfg;
    t_lamps lamps;
    logic   space;
    logic   fire;

    assign i_in.ready = space;
    assign fire       = i_in.valid && space;

    ptl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ptl_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_op           (i_in.op),
        .i_button_level (i_in.button_level),
        .i_cfg          (cfg),
        .o_lamps        (lamps)
    );

    ptl_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_lamps (lamps),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

// ----- tb/pedestrian_traffic_light_fsm_unit_tb.sv -----
module pedestrian_traffic_light_fsm_unit_tb;
    import ptl_pkg::*;

    // Sequencer phases as this bench tracks them
    typedef enum logic [3:0] {
        ST_CAR_GREEN       = 4'd0,
        ST_CAR_BLINK_A     = 4'd1,
        ST_CAR_RED         = 4'd2,
        ST_CAR_BLINK_B     = 4'd3,
        ST_PED_GREEN_BLINK = 4'd4,
        ST_PED_BLINK_A     = 4'd5,
        ST_PED_BLINK_B     = 4'd6,
        ST_PED_CROSS       = 4'd7,
        ST_PED_CROSS_EXT   = 4'd8,
        ST_PED_BLINK_HOLD  = 4'd9,
        ST_PED_BLINK_BARE  = 4'd10
    } t_phase;

    // Event kinds
    localparam logic EV_TICK  = 1'b0;
    localparam logic EV_PRESS = 1'b1;

    // Lamp words that can be read off directly
    localparam t_lamps CARS_GO   = 6'b100001;
    localparam t_lamps WARN_BOTH = 6'b110011;

    localparam int MaxPrinted = 40;

    // One row of the directed script
    typedef struct packed {
        logic   op;
        logic   level;
        logic   typed;
        t_lamps want;
    } t_row;

    localparam int ScriptLen = 22;
    t_row script [ScriptLen] = '{
        '{EV_TICK,  1'b0, 1'b1, CARS_GO},    // first tick after reset
        '{EV_PRESS, 1'b0, 1'b1, CARS_GO},    // press in green, check starts
        '{EV_PRESS, 1'b0, 1'b1, CARS_GO},    // ignored while checking
        '{EV_TICK,  1'b1, 1'b1, CARS_GO},    // long press dropped
        '{EV_PRESS, 1'b1, 1'b1, CARS_GO},    // level ignored on a press
        '{EV_TICK,  1'b0, 1'b1, WARN_BOTH},  // short press, pedestrian mode
        '{EV_PRESS, 1'b0, 1'b1, WARN_BOTH},  // ignored in pedestrian mode
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b1, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b1, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_PRESS, 1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b1, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0},
        '{EV_TICK,  1'b0, 1'b0, 6'b0}
    };

    logic i_clk;
    logic i_rst_n;

    ptl_in_if  ev_ch ();
    ptl_cfg_if cfg_ch ();
    ptl_out_if lamp_ch ();

    pedestrian_traffic_light_fsm_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_ch),
        .i_cfg   (cfg_ch),
        .o_out   (lamp_ch)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // Light sequencer state of the predictor
    t_phase     cur_phase;
    logic [7:0] tick_cnt;
    logic [4:0] blink_cnt;
    logic       blink_lit;
    logic       req_pending;
    logic       req_checking;
    logic [7:0] steady_ticks;
    logic [4:0] blink_total;

    t_lamps lamps_due [$];
    int     mismatches;
    int     words_seen;

    // Side info for the word on the event channel
    logic   row_typed;
    t_lamps row_want;

    // Idle control
    bit no_idle;
    bit hold_request;

    function automatic bit in_cycle(t_phase p);
        return p <= ST_CAR_BLINK_B;
    endfunction

    function automatic bit blinking(t_phase p);
        return p inside {ST_CAR_BLINK_A, ST_CAR_BLINK_B, ST_PED_GREEN_BLINK,
                         ST_PED_BLINK_A, ST_PED_BLINK_B, ST_PED_BLINK_HOLD,
                         ST_PED_BLINK_BARE};
    endfunction

    function automatic t_phase successor(t_phase p);
        case (p)
            ST_CAR_GREEN:     return ST_CAR_BLINK_A;
            ST_CAR_BLINK_A:   return ST_CAR_RED;
            ST_CAR_RED:       return ST_CAR_BLINK_B;
            ST_PED_GREEN_BLINK,
            ST_PED_BLINK_A,
            ST_PED_BLINK_B:   return ST_PED_CROSS;
            ST_PED_CROSS:     return ST_PED_BLINK_HOLD;
            ST_PED_CROSS_EXT: return ST_PED_BLINK_BARE;
            default:          return ST_CAR_GREEN;
        endcase
    endfunction

    // Phase entry; a pending request is checked at once in the normal cycle
    task automatic enter_phase(t_phase p);
        cur_phase = p;
        tick_cnt  = '0;
        blink_cnt = '0;
        blink_lit = blinking(p);
        if (in_cycle(p) && req_pending) begin
            req_checking = 1'b1;
            blink_lit    = 1'b0;
        end
    endtask

    task automatic apply_tick(logic level);
        logic [7:0] steady_lim;
        logic [4:0] blink_lim;
        steady_lim = (steady_ticks == 0) ? 8'd1 : steady_ticks;
        blink_lim  = (blink_total == 0) ? 5'd1 : blink_total;
        if (req_checking) begin
            // check tick: long press drops the request, short starts the walk
            req_checking = 1'b0;
            req_pending  = 1'b0;
            if (level) begin
                if (blinking(cur_phase))
                    blink_lit = 1'b1;
            end else begin
                case (cur_phase)
                    ST_CAR_GREEN:   enter_phase(ST_PED_GREEN_BLINK);
                    ST_CAR_BLINK_A: enter_phase(ST_PED_BLINK_A);
                    ST_CAR_RED:     enter_phase(ST_PED_CROSS_EXT);
                    default:        enter_phase(ST_PED_BLINK_B);
                endcase
            end
        end else if (blinking(cur_phase)) begin
            if (blink_lit) begin
                blink_lit = 1'b0;
            end else begin
                blink_cnt = blink_cnt + 5'd1;
                if (blink_cnt >= blink_lim)
                    enter_phase(successor(cur_phase));
                else if (in_cycle(cur_phase) && req_pending)
                    req_checking = 1'b1;
                else
                    blink_lit = 1'b1;
            end
        end else begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= steady_lim)
                enter_phase(successor(cur_phase));
        end
    endtask

    // Lamps after one event
    task automatic predict_lamps(logic op, logic level, output t_lamps lamps);
        logic y;
        if (cur_phase > ST_PED_BLINK_BARE) begin
            cur_phase    = ST_CAR_GREEN;
            tick_cnt     = '0;
            blink_cnt    = '0;
            blink_lit    = 1'b0;
            req_pending  = 1'b0;
            req_checking = 1'b0;
        end
        if (op == EV_PRESS) begin
            if (in_cycle(cur_phase) && !req_checking && !req_pending) begin
                req_pending = 1'b1;
                if (cur_phase == ST_CAR_GREEN || cur_phase == ST_CAR_RED)
                    req_checking = 1'b1;
            end
        end else begin
            apply_tick(level);
        end
        y     = blink_lit;
        lamps = '0;
        case (cur_phase)
            ST_CAR_GREEN: begin
                lamps.car_green = 1'b1;
                lamps.walk_red  = 1'b1;
            end
            ST_CAR_BLINK_A: begin
                lamps.car_yellow = y;
                lamps.walk_red   = 1'b1;
            end
            ST_CAR_RED, ST_PED_CROSS, ST_PED_CROSS_EXT: begin
                lamps.car_red    = 1'b1;
                lamps.walk_green = 1'b1;
            end
            ST_CAR_BLINK_B: lamps.car_yellow = y;
            ST_PED_GREEN_BLINK: begin
                lamps.car_green   = 1'b1;
                lamps.walk_red    = 1'b1;
                lamps.car_yellow  = y;
                lamps.walk_yellow = y;
            end
            ST_PED_BLINK_A: begin
                lamps.walk_red    = 1'b1;
                lamps.car_yellow  = y;
                lamps.walk_yellow = y;
            end
            ST_PED_BLINK_HOLD: begin
                lamps.car_red     = 1'b1;
                lamps.walk_green  = 1'b1;
                lamps.car_yellow  = y;
                lamps.walk_yellow = y;
            end
            default: begin
                lamps.car_yellow  = y;
                lamps.walk_yellow = y;
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [5:0] got, logic [5:0] want);
        if (mismatches < MaxPrinted)
            $display("MISMATCH word %0d %s: got %b expected %b",
                     words_seen, what, got, want);
        mismatches++;
    endtask

    // Monitor: register writes, lamp words and accepted events
    always @(posedge i_clk) begin
        t_lamps lamps;
        t_lamps due;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_PHASE_TICKS:  steady_ticks = cfg_ch.data;
                    CFG_BLINK_CYCLES: blink_total  = cfg_ch.data[4:0];
                    default: ;
                endcase
            end
            if (lamp_ch.valid && lamp_ch.ready) begin
                lamps = {lamp_ch.car_green, lamp_ch.car_yellow, lamp_ch.car_red,
                         lamp_ch.walk_green, lamp_ch.walk_yellow, lamp_ch.walk_red};
                if (lamps_due.size() == 0) begin
                    report_mismatch("unexpected word", lamps, 6'b0);
                end else begin
                    due = lamps_due.pop_front();
                    if (lamps.car_green != due.car_green)
                        report_mismatch("car_green", lamps, due);
                    if (lamps.car_yellow != due.car_yellow)
                        report_mismatch("car_yellow", lamps, due);
                    if (lamps.car_red != due.car_red)
                        report_mismatch("car_red", lamps, due);
                    if (lamps.walk_green != due.walk_green)
                        report_mismatch("walk_green", lamps, due);
                    if (lamps.walk_yellow != due.walk_yellow)
                        report_mismatch("walk_yellow", lamps, due);
                    if (lamps.walk_red != due.walk_red)
                        report_mismatch("walk_red", lamps, due);
                end
                words_seen++;
            end
            if (ev_ch.valid && ev_ch.ready) begin
                predict_lamps(ev_ch.op, ev_ch.button_level, lamps);
                lamps_due.push_back(row_typed ? row_want : lamps);
            end
        end
    end

    // Random gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Lamp side ready: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        int gap_left;
        int burst_left;
        bit hold_done;
        hold_left  = 0;
        gap_left   = 0;
        burst_left = 0;
        hold_done  = 1'b0;
        lamp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                lamp_ch.ready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                lamp_ch.ready <= 1'b0;
                gap_left--;
            end else begin
                lamp_ch.ready <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    gap_left   = pick_gap();
                    burst_left = $urandom_range(0, 6);
                end
            end
        end
    end

    // Present one event word; starts and returns at a falling edge
    task automatic send_event(logic op, logic level, logic typed, t_lamps want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ev_ch.valid        <= 1'b1;
        ev_ch.op           <= op;
        ev_ch.button_level <= level;
        row_typed = typed;
        row_want  = want;
        @(posedge i_clk);
        while (!(ev_ch.valid && ev_ch.ready))
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly single ticks, some press-then-tick pairs with random level, a few stray presses
    task automatic send_random(int count);
        int sent;
        int r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_event(EV_PRESS, 1'($urandom_range(0, 1)), 1'b0, 6'b0);
                send_event(EV_TICK, 1'($urandom_range(0, 1)), 1'b0, 6'b0);
                sent += 2;
            end else if (r < 16) begin
                send_event(EV_PRESS, 1'($urandom_range(0, 1)), 1'b0, 6'b0);
                sent++;
            end else begin
                send_event(EV_TICK, 1'($urandom_range(0, 3) == 0), 1'b0, 6'b0);
                sent++;
            end
        end
    endtask

    // Wait until every lamp word has come back
    task automatic wait_idle();
        ev_ch.valid <= 1'b0;
        while (lamps_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CfgDataW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!(cfg_ch.valid && cfg_ch.ready))
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Main sequence
    initial begin
        cur_phase    = ST_CAR_GREEN;
        tick_cnt     = '0;
        blink_cnt    = '0;
        blink_lit    = 1'b0;
        req_pending  = 1'b0;
        req_checking = 1'b0;
        steady_ticks = PHASE_TICKS_RST;
        blink_total  = BLINK_CYCLES_RST;
        mismatches   = 0;
        words_seen   = 0;
        row_typed    = 1'b0;
        row_want     = '0;
        no_idle      = 1'b0;
        hold_request = 1'b0;

        i_rst_n            = 1'b0;
        ev_ch.valid        = 1'b0;
        ev_ch.op           = EV_TICK;
        ev_ch.button_level = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_PHASE_TICKS;
        cfg_ch.data        = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed script at reset timing
        for (int i = 0; i < ScriptLen; i++)
            send_event(script[i].op, script[i].level, script[i].typed, script[i].want);
        send_random(180);

        // Shortest phases, with the long lamp-side hold-off
        wait_idle();
        write_reg(CFG_PHASE_TICKS, 8'd1);
        write_reg(CFG_BLINK_CYCLES, 8'd1);
        hold_request = 1'b1;
        send_random(170);

        // Longest phases
        wait_idle();
        write_reg(CFG_PHASE_TICKS, 8'd255);
        write_reg(CFG_BLINK_CYCLES, 8'd31);
        send_random(170);

        // Zero values act as one
        wait_idle();
        write_reg(CFG_PHASE_TICKS, 8'd0);
        write_reg(CFG_BLINK_CYCLES, 8'd0);
        send_random(170);

        // Short phases with no idling on either side
        wait_idle();
        write_reg(CFG_PHASE_TICKS, 8'd3);
        write_reg(CFG_BLINK_CYCLES, 8'd2);
        no_idle = 1'b1;
        send_random(170);
        no_idle = 1'b0;

        // Random settings; blink data carries stray upper bits
        wait_idle();
        write_reg(CFG_PHASE_TICKS, 8'($urandom_range(0, 12)));
        write_reg(CFG_BLINK_CYCLES, 8'($urandom_range(0, 255)));
        send_random(170);

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
